@@ hdl/acbc_pkg.sv @@
// Package for the AES-128 CBC decryption core: payload types, S-box tables,
// GF(2^8) helpers and round functions. No dependencies.
package acbc_pkg;

  localparam int NumRounds = 10;
  localparam int CfgIdxW   = 2;

  typedef enum logic [CfgIdxW-1:0] {
    REG_KEY_HIGH = 2'd0,
    REG_KEY_LOW  = 2'd1,
    REG_IV_HIGH  = 2'd2,
    REG_IV_LOW   = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [63:0] cipher_high;
    logic [63:0] cipher_low;
    logic        first_block;
    logic        last_block;
  } in_item_t;

  typedef struct packed {
    logic [63:0] plain_high;
    logic [63:0] plain_low;
    logic        final_block;
    logic [4:0]  valid_bytes;
  } out_item_t;

  // Data carried from one round cell to the next.
  typedef struct packed {
    logic         vld;
    logic [127:0] state;
    logic [127:0] cipher;
    logic         first_block;
    logic         last_block;
  } cell_bus_t;

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] r;
    unique case (a)
      8'h00: r=8'h63; 8'h01: r=8'h7c; 8'h02: r=8'h77; 8'h03: r=8'h7b;
      8'h04: r=8'hf2; 8'h05: r=8'h6b; 8'h06: r=8'h6f; 8'h07: r=8'hc5;
      8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0a: r=8'h67; 8'h0b: r=8'h2b;
      8'h0c: r=8'hfe; 8'h0d: r=8'hd7; 8'h0e: r=8'hab; 8'h0f: r=8'h76;
      8'h10: r=8'hca; 8'h11: r=8'h82; 8'h12: r=8'hc9; 8'h13: r=8'h7d;
      8'h14: r=8'hfa; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hf0;
      8'h18: r=8'had; 8'h19: r=8'hd4; 8'h1a: r=8'ha2; 8'h1b: r=8'haf;
      8'h1c: r=8'h9c; 8'h1d: r=8'ha4; 8'h1e: r=8'h72; 8'h1f: r=8'hc0;
      8'h20: r=8'hb7; 8'h21: r=8'hfd; 8'h22: r=8'h93; 8'h23: r=8'h26;
      8'h24: r=8'h36; 8'h25: r=8'h3f; 8'h26: r=8'hf7; 8'h27: r=8'hcc;
      8'h28: r=8'h34; 8'h29: r=8'ha5; 8'h2a: r=8'he5; 8'h2b: r=8'hf1;
      8'h2c: r=8'h71; 8'h2d: r=8'hd8; 8'h2e: r=8'h31; 8'h2f: r=8'h15;
      8'h30: r=8'h04; 8'h31: r=8'hc7; 8'h32: r=8'h23; 8'h33: r=8'hc3;
      8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9a;
      8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3a: r=8'h80; 8'h3b: r=8'he2;
      8'h3c: r=8'heb; 8'h3d: r=8'h27; 8'h3e: r=8'hb2; 8'h3f: r=8'h75;
      8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2c; 8'h43: r=8'h1a;
      8'h44: r=8'h1b; 8'h45: r=8'h6e; 8'h46: r=8'h5a; 8'h47: r=8'ha0;
      8'h48: r=8'h52; 8'h49: r=8'h3b; 8'h4a: r=8'hd6; 8'h4b: r=8'hb3;
      8'h4c: r=8'h29; 8'h4d: r=8'he3; 8'h4e: r=8'h2f; 8'h4f: r=8'h84;
      8'h50: r=8'h53; 8'h51: r=8'hd1; 8'h52: r=8'h00; 8'h53: r=8'hed;
      8'h54: r=8'h20; 8'h55: r=8'hfc; 8'h56: r=8'hb1; 8'h57: r=8'h5b;
      8'h58: r=8'h6a; 8'h59: r=8'hcb; 8'h5a: r=8'hbe; 8'h5b: r=8'h39;
      8'h5c: r=8'h4a; 8'h5d: r=8'h4c; 8'h5e: r=8'h58; 8'h5f: r=8'hcf;
      8'h60: r=8'hd0; 8'h61: r=8'hef; 8'h62: r=8'haa; 8'h63: r=8'hfb;
      8'h64: r=8'h43; 8'h65: r=8'h4d; 8'h66: r=8'h33; 8'h67: r=8'h85;
      8'h68: r=8'h45; 8'h69: r=8'hf9; 8'h6a: r=8'h02; 8'h6b: r=8'h7f;
      8'h6c: r=8'h50; 8'h6d: r=8'h3c; 8'h6e: r=8'h9f; 8'h6f: r=8'ha8;
      8'h70: r=8'h51; 8'h71: r=8'ha3; 8'h72: r=8'h40; 8'h73: r=8'h8f;
      8'h74: r=8'h92; 8'h75: r=8'h9d; 8'h76: r=8'h38; 8'h77: r=8'hf5;
      8'h78: r=8'hbc; 8'h79: r=8'hb6; 8'h7a: r=8'hda; 8'h7b: r=8'h21;
      8'h7c: r=8'h10; 8'h7d: r=8'hff; 8'h7e: r=8'hf3; 8'h7f: r=8'hd2;
      8'h80: r=8'hcd; 8'h81: r=8'h0c; 8'h82: r=8'h13; 8'h83: r=8'hec;
      8'h84: r=8'h5f; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
      8'h88: r=8'hc4; 8'h89: r=8'ha7; 8'h8a: r=8'h7e; 8'h8b: r=8'h3d;
      8'h8c: r=8'h64; 8'h8d: r=8'h5d; 8'h8e: r=8'h19; 8'h8f: r=8'h73;
      8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4f; 8'h93: r=8'hdc;
      8'h94: r=8'h22; 8'h95: r=8'h2a; 8'h96: r=8'h90; 8'h97: r=8'h88;
      8'h98: r=8'h46; 8'h99: r=8'hee; 8'h9a: r=8'hb8; 8'h9b: r=8'h14;
      8'h9c: r=8'hde; 8'h9d: r=8'h5e; 8'h9e: r=8'h0b; 8'h9f: r=8'hdb;
      8'ha0: r=8'he0; 8'ha1: r=8'h32; 8'ha2: r=8'h3a; 8'ha3: r=8'h0a;
      8'ha4: r=8'h49; 8'ha5: r=8'h06; 8'ha6: r=8'h24; 8'ha7: r=8'h5c;
      8'ha8: r=8'hc2; 8'ha9: r=8'hd3; 8'haa: r=8'hac; 8'hab: r=8'h62;
      8'hac: r=8'h91; 8'had: r=8'h95; 8'hae: r=8'he4; 8'haf: r=8'h79;
      8'hb0: r=8'he7; 8'hb1: r=8'hc8; 8'hb2: r=8'h37; 8'hb3: r=8'h6d;
      8'hb4: r=8'h8d; 8'hb5: r=8'hd5; 8'hb6: r=8'h4e; 8'hb7: r=8'ha9;
      8'hb8: r=8'h6c; 8'hb9: r=8'h56; 8'hba: r=8'hf4; 8'hbb: r=8'hea;
      8'hbc: r=8'h65; 8'hbd: r=8'h7a; 8'hbe: r=8'hae; 8'hbf: r=8'h08;
      8'hc0: r=8'hba; 8'hc1: r=8'h78; 8'hc2: r=8'h25; 8'hc3: r=8'h2e;
      8'hc4: r=8'h1c; 8'hc5: r=8'ha6; 8'hc6: r=8'hb4; 8'hc7: r=8'hc6;
      8'hc8: r=8'he8; 8'hc9: r=8'hdd; 8'hca: r=8'h74; 8'hcb: r=8'h1f;
      8'hcc: r=8'h4b; 8'hcd: r=8'hbd; 8'hce: r=8'h8b; 8'hcf: r=8'h8a;
      8'hd0: r=8'h70; 8'hd1: r=8'h3e; 8'hd2: r=8'hb5; 8'hd3: r=8'h66;
      8'hd4: r=8'h48; 8'hd5: r=8'h03; 8'hd6: r=8'hf6; 8'hd7: r=8'h0e;
      8'hd8: r=8'h61; 8'hd9: r=8'h35; 8'hda: r=8'h57; 8'hdb: r=8'hb9;
      8'hdc: r=8'h86; 8'hdd: r=8'hc1; 8'hde: r=8'h1d; 8'hdf: r=8'h9e;
      8'he0: r=8'he1; 8'he1: r=8'hf8; 8'he2: r=8'h98; 8'he3: r=8'h11;
      8'he4: r=8'h69; 8'he5: r=8'hd9; 8'he6: r=8'h8e; 8'he7: r=8'h94;
      8'he8: r=8'h9b; 8'he9: r=8'h1e; 8'hea: r=8'h87; 8'heb: r=8'he9;
      8'hec: r=8'hce; 8'hed: r=8'h55; 8'hee: r=8'h28; 8'hef: r=8'hdf;
      8'hf0: r=8'h8c; 8'hf1: r=8'ha1; 8'hf2: r=8'h89; 8'hf3: r=8'h0d;
      8'hf4: r=8'hbf; 8'hf5: r=8'he6; 8'hf6: r=8'h42; 8'hf7: r=8'h68;
      8'hf8: r=8'h41; 8'hf9: r=8'h99; 8'hfa: r=8'h2d; 8'hfb: r=8'h0f;
      8'hfc: r=8'hb0; 8'hfd: r=8'h54; 8'hfe: r=8'hbb; 8'hff: r=8'h16;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] inv_sbox(input logic [7:0] a);
    logic [7:0] r;
    unique case (a)
      8'h00: r=8'h52; 8'h01: r=8'h09; 8'h02: r=8'h6a; 8'h03: r=8'hd5;
      8'h04: r=8'h30; 8'h05: r=8'h36; 8'h06: r=8'ha5; 8'h07: r=8'h38;
      8'h08: r=8'hbf; 8'h09: r=8'h40; 8'h0a: r=8'ha3; 8'h0b: r=8'h9e;
      8'h0c: r=8'h81; 8'h0d: r=8'hf3; 8'h0e: r=8'hd7; 8'h0f: r=8'hfb;
      8'h10: r=8'h7c; 8'h11: r=8'he3; 8'h12: r=8'h39; 8'h13: r=8'h82;
      8'h14: r=8'h9b; 8'h15: r=8'h2f; 8'h16: r=8'hff; 8'h17: r=8'h87;
      8'h18: r=8'h34; 8'h19: r=8'h8e; 8'h1a: r=8'h43; 8'h1b: r=8'h44;
      8'h1c: r=8'hc4; 8'h1d: r=8'hde; 8'h1e: r=8'he9; 8'h1f: r=8'hcb;
      8'h20: r=8'h54; 8'h21: r=8'h7b; 8'h22: r=8'h94; 8'h23: r=8'h32;
      8'h24: r=8'ha6; 8'h25: r=8'hc2; 8'h26: r=8'h23; 8'h27: r=8'h3d;
      8'h28: r=8'hee; 8'h29: r=8'h4c; 8'h2a: r=8'h95; 8'h2b: r=8'h0b;
      8'h2c: r=8'h42; 8'h2d: r=8'hfa; 8'h2e: r=8'hc3; 8'h2f: r=8'h4e;
      8'h30: r=8'h08; 8'h31: r=8'h2e; 8'h32: r=8'ha1; 8'h33: r=8'h66;
      8'h34: r=8'h28; 8'h35: r=8'hd9; 8'h36: r=8'h24; 8'h37: r=8'hb2;
      8'h38: r=8'h76; 8'h39: r=8'h5b; 8'h3a: r=8'ha2; 8'h3b: r=8'h49;
      8'h3c: r=8'h6d; 8'h3d: r=8'h8b; 8'h3e: r=8'hd1; 8'h3f: r=8'h25;
      8'h40: r=8'h72; 8'h41: r=8'hf8; 8'h42: r=8'hf6; 8'h43: r=8'h64;
      8'h44: r=8'h86; 8'h45: r=8'h68; 8'h46: r=8'h98; 8'h47: r=8'h16;
      8'h48: r=8'hd4; 8'h49: r=8'ha4; 8'h4a: r=8'h5c; 8'h4b: r=8'hcc;
      8'h4c: r=8'h5d; 8'h4d: r=8'h65; 8'h4e: r=8'hb6; 8'h4f: r=8'h92;
      8'h50: r=8'h6c; 8'h51: r=8'h70; 8'h52: r=8'h48; 8'h53: r=8'h50;
      8'h54: r=8'hfd; 8'h55: r=8'hed; 8'h56: r=8'hb9; 8'h57: r=8'hda;
      8'h58: r=8'h5e; 8'h59: r=8'h15; 8'h5a: r=8'h46; 8'h5b: r=8'h57;
      8'h5c: r=8'ha7; 8'h5d: r=8'h8d; 8'h5e: r=8'h9d; 8'h5f: r=8'h84;
      8'h60: r=8'h90; 8'h61: r=8'hd8; 8'h62: r=8'hab; 8'h63: r=8'h00;
      8'h64: r=8'h8c; 8'h65: r=8'hbc; 8'h66: r=8'hd3; 8'h67: r=8'h0a;
      8'h68: r=8'hf7; 8'h69: r=8'he4; 8'h6a: r=8'h58; 8'h6b: r=8'h05;
      8'h6c: r=8'hb8; 8'h6d: r=8'hb3; 8'h6e: r=8'h45; 8'h6f: r=8'h06;
      8'h70: r=8'hd0; 8'h71: r=8'h2c; 8'h72: r=8'h1e; 8'h73: r=8'h8f;
      8'h74: r=8'hca; 8'h75: r=8'h3f; 8'h76: r=8'h0f; 8'h77: r=8'h02;
      8'h78: r=8'hc1; 8'h79: r=8'haf; 8'h7a: r=8'hbd; 8'h7b: r=8'h03;
      8'h7c: r=8'h01; 8'h7d: r=8'h13; 8'h7e: r=8'h8a; 8'h7f: r=8'h6b;
      8'h80: r=8'h3a; 8'h81: r=8'h91; 8'h82: r=8'h11; 8'h83: r=8'h41;
      8'h84: r=8'h4f; 8'h85: r=8'h67; 8'h86: r=8'hdc; 8'h87: r=8'hea;
      8'h88: r=8'h97; 8'h89: r=8'hf2; 8'h8a: r=8'hcf; 8'h8b: r=8'hce;
      8'h8c: r=8'hf0; 8'h8d: r=8'hb4; 8'h8e: r=8'he6; 8'h8f: r=8'h73;
      8'h90: r=8'h96; 8'h91: r=8'hac; 8'h92: r=8'h74; 8'h93: r=8'h22;
      8'h94: r=8'he7; 8'h95: r=8'had; 8'h96: r=8'h35; 8'h97: r=8'h85;
      8'h98: r=8'he2; 8'h99: r=8'hf9; 8'h9a: r=8'h37; 8'h9b: r=8'he8;
      8'h9c: r=8'h1c; 8'h9d: r=8'h75; 8'h9e: r=8'hdf; 8'h9f: r=8'h6e;
      8'ha0: r=8'h47; 8'ha1: r=8'hf1; 8'ha2: r=8'h1a; 8'ha3: r=8'h71;
      8'ha4: r=8'h1d; 8'ha5: r=8'h29; 8'ha6: r=8'hc5; 8'ha7: r=8'h89;
      8'ha8: r=8'h6f; 8'ha9: r=8'hb7; 8'haa: r=8'h62; 8'hab: r=8'h0e;
      8'hac: r=8'haa; 8'had: r=8'h18; 8'hae: r=8'hbe; 8'haf: r=8'h1b;
      8'hb0: r=8'hfc; 8'hb1: r=8'h56; 8'hb2: r=8'h3e; 8'hb3: r=8'h4b;
      8'hb4: r=8'hc6; 8'hb5: r=8'hd2; 8'hb6: r=8'h79; 8'hb7: r=8'h20;
      8'hb8: r=8'h9a; 8'hb9: r=8'hdb; 8'hba: r=8'hc0; 8'hbb: r=8'hfe;
      8'hbc: r=8'h78; 8'hbd: r=8'hcd; 8'hbe: r=8'h5a; 8'hbf: r=8'hf4;
      8'hc0: r=8'h1f; 8'hc1: r=8'hdd; 8'hc2: r=8'ha8; 8'hc3: r=8'h33;
      8'hc4: r=8'h88; 8'hc5: r=8'h07; 8'hc6: r=8'hc7; 8'hc7: r=8'h31;
      8'hc8: r=8'hb1; 8'hc9: r=8'h12; 8'hca: r=8'h10; 8'hcb: r=8'h59;
      8'hcc: r=8'h27; 8'hcd: r=8'h80; 8'hce: r=8'hec; 8'hcf: r=8'h5f;
      8'hd0: r=8'h60; 8'hd1: r=8'h51; 8'hd2: r=8'h7f; 8'hd3: r=8'ha9;
      8'hd4: r=8'h19; 8'hd5: r=8'hb5; 8'hd6: r=8'h4a; 8'hd7: r=8'h0d;
      8'hd8: r=8'h2d; 8'hd9: r=8'he5; 8'hda: r=8'h7a; 8'hdb: r=8'h9f;
      8'hdc: r=8'h93; 8'hdd: r=8'hc9; 8'hde: r=8'h9c; 8'hdf: r=8'hef;
      8'he0: r=8'ha0; 8'he1: r=8'he0; 8'he2: r=8'h3b; 8'he3: r=8'h4d;
      8'he4: r=8'hae; 8'he5: r=8'h2a; 8'he6: r=8'hf5; 8'he7: r=8'hb0;
      8'he8: r=8'hc8; 8'he9: r=8'heb; 8'hea: r=8'hbb; 8'heb: r=8'h3c;
      8'hec: r=8'h83; 8'hed: r=8'h53; 8'hee: r=8'h99; 8'hef: r=8'h61;
      8'hf0: r=8'h17; 8'hf1: r=8'h2b; 8'hf2: r=8'h04; 8'hf3: r=8'h7e;
      8'hf4: r=8'hba; 8'hf5: r=8'h77; 8'hf6: r=8'hd6; 8'hf7: r=8'h26;
      8'hf8: r=8'he1; 8'hf9: r=8'h69; 8'hfa: r=8'h14; 8'hfb: r=8'h63;
      8'hfc: r=8'h55; 8'hfd: r=8'h21; 8'hfe: r=8'h0c; 8'hff: r=8'h7d;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // Byte i of a 128-bit block sits at bits 127-8i downto 120-8i.
  function automatic logic [7:0] get_byte(input logic [127:0] s, input int i);
    return s[127-8*i -: 8];
  endfunction

  // InvShiftRows followed by InvSubBytes.
  function automatic logic [127:0] inv_shift_sub(input logic [127:0] s);
    logic [127:0] t;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[127-8*(r+4*c) -: 8] = inv_sbox(get_byte(s, r + 4*((c - r + 4) % 4)));
      end
    end
    return t;
  endfunction

  function automatic logic [127:0] inv_mix(input logic [127:0] s);
    logic [127:0] t;
    logic [7:0] a0, a1, a2, a3;
    logic [7:0] x0, x1, x2, x3, y0, y1, y2, y3, z0, z1, z2, z3;
    for (int c = 0; c < 4; c++) begin
      a0 = get_byte(s, 4*c);   a1 = get_byte(s, 4*c+1);
      a2 = get_byte(s, 4*c+2); a3 = get_byte(s, 4*c+3);
      x0 = xtime(a0); x1 = xtime(a1); x2 = xtime(a2); x3 = xtime(a3);
      y0 = xtime(x0); y1 = xtime(x1); y2 = xtime(x2); y3 = xtime(x3);
      z0 = xtime(y0); z1 = xtime(y1); z2 = xtime(y2); z3 = xtime(y3);
      // 0e = 8+4+2, 0b = 8+2+1, 0d = 8+4+1, 09 = 8+1
      t[127-8*(4*c) -: 8]   = (z0^y0^x0) ^ (z1^x1^a1) ^ (z2^y2^a2) ^ (z3^a3);
      t[127-8*(4*c+1) -: 8] = (z0^a0) ^ (z1^y1^x1) ^ (z2^x2^a2) ^ (z3^y3^a3);
      t[127-8*(4*c+2) -: 8] = (z0^y0^a0) ^ (z1^a1) ^ (z2^y2^x2) ^ (z3^x3^a3);
      t[127-8*(4*c+3) -: 8] = (z0^x0^a0) ^ (z1^y1^a1) ^ (z2^a2) ^ (z3^y3^x3);
    end
    return t;
  endfunction

  // One key-schedule step: round key r from round key r-1.
  function automatic logic [127:0] next_round_key(input logic [127:0] k,
                                                  input logic [7:0] rcon);
    logic [31:0] w0, w1, w2, w3, t;
    w0 = k[127:96]; w1 = k[95:64]; w2 = k[63:32]; w3 = k[31:0];
    t  = {sbox(w3[23:16]), sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
    t  = t ^ {rcon, 24'h0};
    w0 = w0 ^ t; w1 = w1 ^ w0; w2 = w2 ^ w1; w3 = w3 ^ w2;
    return {w0, w1, w2, w3};
  endfunction

endpackage

@@ hdl/aes128_cbc_decrypt_core.sv @@
// Top level of the AES-128 CBC decryption core: input stage, ten round cells,
// CBC chaining, unpadding and output register. Depends on acbc_pkg.
//
//   channel  direction  handshake               payload
//   in_      input      in_valid / in_ready     in_data  (in_item_t)
//   out_     output     out_valid / out_ready   out_data (out_item_t)
//   cfg_     input      cfg_we                  cfg_index, cfg_wdata
//
// One request enters per cycle while in_ready is high; each passes the input key
// add, ten round cells and the output register. Every stage moves whenever the
// output register is empty or being taken, so a stall at out_ready freezes the
// whole chain. After reset and after a key write, in_ready stays low while the
// key schedule row settles.
// Reset is synchronous and clears valid flags, chaining value and config registers.
module aes128_cbc_decrypt_core
  import acbc_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  in_item_t            in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output out_item_t           out_data,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [63:0]         cfg_wdata
);

  logic [63:0]  key_hi_r, key_lo_r, iv_hi_r, iv_lo_r;
  logic [127:0] round_keys [NumRounds+1];
  logic         advance;
  cell_bus_t    bus [NumRounds+1];
  logic         s0_vld_r, s0_first_r, s0_last_r;
  logic [127:0] s0_state_r, s0_cipher_r;
  logic [127:0] chain_r, chain_nxt, plain;
  logic         out_vld_r;
  out_item_t    out_r;
  logic [7:0]   pad;
  logic [4:0]   vbytes;
  logic [3:0]   settle_r, settle_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_hi_r <= '0;
      key_lo_r <= '0;
      iv_hi_r  <= '0;
      iv_lo_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_KEY_HIGH: key_hi_r <= cfg_wdata;
        REG_KEY_LOW:  key_lo_r <= cfg_wdata;
        REG_IV_HIGH:  iv_hi_r  <= cfg_wdata;
        REG_IV_LOW:   iv_lo_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Requests are held off until every round key reflects the current key.
  always_comb begin
    settle_nxt = settle_r;
    if (cfg_we && (cfg_reg_t'(cfg_index) == REG_KEY_HIGH ||
                   cfg_reg_t'(cfg_index) == REG_KEY_LOW)) begin
      settle_nxt = 4'(NumRounds + 1);
    end else if (settle_r != 4'd0) begin
      settle_nxt = settle_r - 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      settle_r <= 4'(NumRounds + 1);
    end else begin
      settle_r <= settle_nxt;
    end
  end

  acbc_key_expand u_keys (
    .clk        (clk),
    .key        ({key_hi_r, key_lo_r}),
    .round_keys (round_keys)
  );

  assign advance  = !out_vld_r || out_ready;
  assign in_ready = advance && (settle_r == 4'd0);

  // Input stage: initial AddRoundKey with the last round key.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else if (advance) begin
      s0_vld_r <= in_valid && in_ready;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s0_state_r  <= {in_data.cipher_high, in_data.cipher_low} ^ round_keys[NumRounds];
      s0_cipher_r <= {in_data.cipher_high, in_data.cipher_low};
      s0_first_r  <= in_data.first_block;
      s0_last_r   <= in_data.last_block;
    end
  end

  assign bus[0] = '{vld: s0_vld_r, state: s0_state_r, cipher: s0_cipher_r,
                    first_block: s0_first_r, last_block: s0_last_r};

  // Cell i applies round key NumRounds-1-i; the last cell has no InvMixColumns.
  for (genvar i = 0; i < NumRounds; i++) begin : g_cell
    acbc_round_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .advance   (advance),
      .mix_en    (i != NumRounds - 1),
      .round_key (round_keys[NumRounds-1-i]),
      .bus_in    (bus[i]),
      .bus_out   (bus[i+1])
    );
  end

  // Blocks leave the chain in order, so chaining is applied at its end.
  always_comb begin
    plain = bus[NumRounds].state ^
            (bus[NumRounds].first_block ? {iv_hi_r, iv_lo_r} : chain_r);
    chain_nxt = (advance && bus[NumRounds].vld) ? bus[NumRounds].cipher : chain_r;
    pad = plain[7:0];
    vbytes = 5'd16;
    if (bus[NumRounds].last_block && pad != 8'd0 && pad <= 8'd16) begin
      vbytes = 5'(8'd16 - pad);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chain_r   <= '0;
      out_vld_r <= 1'b0;
    end else begin
      chain_r <= chain_nxt;
      if (advance) begin
        out_vld_r <= bus[NumRounds].vld;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_r <= '{plain_high: plain[127:64], plain_low: plain[63:0],
                 final_block: bus[NumRounds].last_block, valid_bytes: vbytes};
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

`ifndef SYNTH
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid && settle_r == 4'd0 |-> in_ready)
    else $error("input blocked with empty output register");
  a_bytes_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.valid_bytes <= 5'd16)
    else $error("valid byte count out of range");
  a_full_nonfinal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.final_block |-> out_data.valid_bytes == 5'd16)
    else $error("non-final block lost bytes");
`endif

endmodule

@@ hdl/acbc_round_cell.sv @@
// One inverse-cipher round cell of the decryption chain.
// Depends on acbc_pkg for the round functions and the cell bus type.
module acbc_round_cell
  import acbc_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         advance,
  input  logic         mix_en,
  input  logic [127:0] round_key,
  input  cell_bus_t    bus_in,
  output cell_bus_t    bus_out
);

  logic         vld_r;
  logic [127:0] state_r, cipher_r, state_nxt;
  logic         first_r, last_r;

  always_comb begin
    state_nxt = inv_shift_sub(bus_in.state) ^ round_key;
    if (mix_en) begin
      state_nxt = inv_mix(state_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (advance) begin
      vld_r <= bus_in.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      state_r  <= state_nxt;
      cipher_r <= bus_in.cipher;
      first_r  <= bus_in.first_block;
      last_r   <= bus_in.last_block;
    end
  end

  assign bus_out = '{vld: vld_r, state: state_r, cipher: cipher_r,
                     first_block: first_r, last_block: last_r};

endmodule

@@ hdl/acbc_key_expand.sv @@
// Key schedule: holds the eleven AES-128 round keys, expanded in a row of
// registers from the configured key. Depends on acbc_pkg.
module acbc_key_expand
  import acbc_pkg::*;
(
  input  logic         clk,
  input  logic [127:0] key,
  output logic [127:0] round_keys [NumRounds+1]
);

  // Each round key is recomputed from the one before it every cycle, so a key
  // write settles through the row from rk_r[0] to rk_r[NumRounds] in order.
  logic [127:0] rk_r [NumRounds+1];
  logic [7:0]   rcon [NumRounds+1];

  always_comb begin
    rcon[0] = 8'h00;
    rcon[1] = 8'h01;
    for (int i = 2; i <= NumRounds; i++) begin
      rcon[i] = xtime(rcon[i-1]);
    end
  end

  always_ff @(posedge clk) begin
    rk_r[0] <= key;
    for (int i = 1; i <= NumRounds; i++) begin
      rk_r[i] <= next_round_key(rk_r[i-1], rcon[i]);
    end
  end

  assign round_keys = rk_r;

endmodule

@@ dv/tb_aes128_cbc_decrypt_core.sv @@
// Self-checking testbench for the AES-128 CBC decryption core: a behavioral
// inverse cipher with chaining and unpadding predicts every plaintext block.
// Depends on acbc_pkg and aes128_cbc_decrypt_core.
module tb_aes128_cbc_decrypt_core;
  import acbc_pkg::*;

  localparam int ClkPeriod  = 20;
  localparam int Latency    = 12;
  localparam int KeySettle  = 11;
  localparam int CycleLimit = 400000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;
  logic        cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [63:0] cfg_wdata = '0;

  // Predictor state.
  logic [63:0]  key_hi, key_lo, iv_hi, iv_lo;
  logic [127:0] chain_blk;
  logic [127:0] rkeys [0:10];
  out_item_t    plain_q [$];

  int error_count = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_cycles = 0;

  aes128_cbc_decrypt_core DUT (.*);

  always #(ClkPeriod / 2) clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Standard forward S-box built from GF inverse plus affine map.
  function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    p = '0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p ^= a;
      a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    end
    return p;
  endfunction

  logic [7:0] fwd_sbox [0:255];
  logic [7:0] rev_sbox [0:255];

  task automatic build_sboxes();
    logic [7:0] inv, s;
    for (int x = 0; x < 256; x++) begin
      inv = 8'h00;
      for (int y = 1; y < 256; y++)
        if (gmul(x[7:0], y[7:0]) == 8'h01) inv = y[7:0];
      s = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^
          {inv[4:0], inv[7:5]} ^ {inv[3:0], inv[7:4]} ^ 8'h63;
      fwd_sbox[x] = s;
      rev_sbox[s] = x[7:0];
    end
  endtask

  task automatic expand_keys();
    logic [31:0] w [0:43];
    logic [31:0] t;
    logic [7:0] rc;
    rc = 8'h01;
    {w[0], w[1], w[2], w[3]} = {key_hi, key_lo};
    for (int i = 4; i < 44; i++) begin
      t = w[i-1];
      if (i % 4 == 0) begin
        t = {fwd_sbox[t[23:16]], fwd_sbox[t[15:8]], fwd_sbox[t[7:0]], fwd_sbox[t[31:24]]}
            ^ {rc, 24'h0};
        rc = gmul(rc, 8'h02);
      end
      w[i] = w[i-4] ^ t;
    end
    for (int r = 0; r < 11; r++) rkeys[r] = {w[4*r], w[4*r+1], w[4*r+2], w[4*r+3]};
  endtask

  function automatic logic [127:0] unshift_unsub(input logic [127:0] s);
    logic [127:0] t;
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        t[127-8*(r+4*c) -: 8] = rev_sbox[s[127-8*(r+4*((c-r+4)%4)) -: 8]];
    return t;
  endfunction

  function automatic logic [127:0] unmix(input logic [127:0] s);
    logic [127:0] t;
    logic [7:0] a [0:3];
    for (int c = 0; c < 4; c++) begin
      for (int k = 0; k < 4; k++) a[k] = s[127-8*(4*c+k) -: 8];
      for (int k = 0; k < 4; k++)
        t[127-8*(4*c+k) -: 8] = gmul(a[k], 8'h0e) ^ gmul(a[(k+1)%4], 8'h0b) ^
                                gmul(a[(k+2)%4], 8'h0d) ^ gmul(a[(k+3)%4], 8'h09);
    end
    return t;
  endfunction

  function automatic out_item_t decrypt_block(input in_item_t req);
    logic [127:0] s, cv;
    out_item_t res;
    logic [7:0] pad;
    s = {req.cipher_high, req.cipher_low} ^ rkeys[10];
    for (int r = 9; r >= 1; r--) s = unmix(unshift_unsub(s) ^ rkeys[r]);
    s = unshift_unsub(s) ^ rkeys[0];
    cv = req.first_block ? {iv_hi, iv_lo} : chain_blk;
    chain_blk = {req.cipher_high, req.cipher_low};
    s ^= cv;
    res.plain_high = s[127:64];
    res.plain_low = s[63:0];
    res.final_block = req.last_block;
    res.valid_bytes = 5'd16;
    pad = s[7:0];
    if (req.last_block && pad != 0 && pad <= 16) res.valid_bytes = 5'(16 - pad);
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("MISMATCH %s: got %h expected %h at cycle %0d", what, got, want, cycle_count);
    error_count++;
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [63:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_KEY_HIGH: key_hi = val;
      REG_KEY_LOW:  key_lo = val;
      REG_IV_HIGH:  iv_hi = val;
      default:      iv_lo = val;
    endcase
    if (idx == REG_KEY_HIGH || idx == REG_KEY_LOW) begin
      expand_keys();
      repeat (KeySettle + 2) @(negedge clk);
    end
  endtask

  // Called at a falling edge; drops the request line and waits for every result.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (plain_q.size() != 0) @(negedge clk);
    repeat (Latency + 2) @(negedge clk);
  endtask

  // Sends one request; called at a falling edge, returns at a falling edge.
  // The request line stays high on return so that requests can follow back to back.
  task automatic send_block(input logic [63:0] hi, input logic [63:0] lo,
                            input logic first, input logic last);
    in_item_t req;
    req = '{cipher_high: hi, cipher_low: lo, first_block: first, last_block: last};
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (!in_ready);
    plain_q.insert(plain_q.size(), decrypt_block(req));
    @(negedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Receiver: stall at random or for a long hold-off, and check at the rising edge.
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= !(recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (plain_q.size() == 0) begin
        report_mismatch("unexpected result", out_data.plain_high, '0);
      end else begin
        want = plain_q.pop_front();
        if (out_data.plain_high !== want.plain_high)
          report_mismatch("plain_high", out_data.plain_high, want.plain_high);
        if (out_data.plain_low !== want.plain_low)
          report_mismatch("plain_low", out_data.plain_low, want.plain_low);
        if (out_data.final_block !== want.final_block)
          report_mismatch("final_block", 64'(out_data.final_block), 64'(want.final_block));
        if (out_data.valid_bytes !== want.valid_bytes)
          report_mismatch("valid_bytes", 64'(out_data.valid_bytes), 64'(want.valid_bytes));
      end
    end
  end

  // Known FIPS-197 vector plus field extremes and every unpadding case.
  task automatic test_directed();
    write_reg(REG_KEY_HIGH, 64'h0001020304050607);
    write_reg(REG_KEY_LOW, 64'h08090a0b0c0d0e0f);
    send_block(64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a, 1'b1, 1'b0);
    send_block(64'h0, 64'h0, 1'b0, 1'b0);
    send_block('1, '1, 1'b0, 1'b1);
    send_block(64'h0, 64'h0, 1'b0, 1'b1);
    wait_drained();
    write_reg(REG_IV_HIGH, '1);
    write_reg(REG_IV_LOW, '1);
    send_block('1, 64'h0, 1'b1, 1'b1);
    // Unpadding edges: force the last plaintext byte through 0, 1, 15, 16, 17, 255.
    for (int p = 0; p < 6; p++) begin
      logic [7:0] padv;
      logic [127:0] cv;
      padv = (p == 0) ? 8'd0 : (p == 1) ? 8'd1 : (p == 2) ? 8'd15 :
             (p == 3) ? 8'd16 : (p == 4) ? 8'd17 : 8'd255;
      // Choose the IV so that plaintext byte 15 equals padv for cipher zero.
      cv = {64'h0, 64'h0} ^ rkeys[10];
      for (int r = 9; r >= 1; r--) cv = unmix(unshift_unsub(cv) ^ rkeys[r]);
      cv = unshift_unsub(cv) ^ rkeys[0];
      wait_drained();
      write_reg(REG_IV_LOW, {56'h0, cv[7:0] ^ padv});
      send_block(64'h0, 64'h0, 1'b1, 1'b1);
    end
    // An IV written mid-message waits for the next first block.
    send_block(rand64(), rand64(), 1'b1, 1'b0);
    wait_drained();
    write_reg(REG_IV_HIGH, rand64());
    send_block(rand64(), rand64(), 1'b0, 1'b1);
    send_block(rand64(), rand64(), 1'b0, 1'b0);
    wait_drained();
  endtask

  // Messages of random length with random content, some stray flags mixed in.
  task automatic run_messages(input int n_blocks);
    int left, msg_len, pos;
    left = n_blocks;
    while (left > 0) begin
      msg_len = $urandom_range(1, 8);
      for (pos = 0; pos < msg_len && left > 0; pos++, left--) begin
        if ($urandom_range(9) == 0)
          send_block(rand64(), rand64(), 1'($urandom), 1'($urandom));
        else
          send_block(rand64(), rand64(), pos == 0, pos == msg_len - 1);
      end
    end
  endtask

  task automatic test_random_phases();
    int idle [4] = '{0, 67, 0, 36};
    int stall [4] = '{0, 0, 67, 36};
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = idle[ph];
      recv_stall_pct = stall[ph];
      write_reg(REG_KEY_HIGH, (ph == 0) ? '1 : rand64());
      write_reg(REG_KEY_LOW, (ph == 0) ? '1 : (ph == 1) ? '0 : rand64());
      write_reg(REG_IV_HIGH, rand64());
      write_reg(REG_IV_LOW, rand64());
      run_messages(300);
      wait_drained();
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;
  endtask

  // Long output hold-off so the pipeline fills and drops in_ready.
  task automatic test_backpressure();
    @(negedge clk);
    hold_cycles = 200;
    run_messages(60);
    send_idle_pct = 50;
    recv_stall_pct = 50;
    run_messages(100);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    wait_drained();
  endtask

  task automatic ref_init();
    build_sboxes();
    key_hi = '0;
    key_lo = '0;
    iv_hi = '0;
    iv_lo = '0;
    chain_blk = '0;
    expand_keys();
  endtask

  initial begin
    ref_init();
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_random_phases();
    test_backpressure();
    wait_drained();
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
